>>> hdl/clns_pkg.sv
package clns_pkg;

	// Request function codes as they arrive on the request channel.
	typedef enum logic [2:0] {
		FUNC_CMD   = 3'd0,
		FUNC_DATA  = 3'd1,
		FUNC_INIT  = 3'd2,
		FUNC_GOTO  = 3'd3,
		FUNC_CLEAR = 3'd4
	} func_t;

	// Classified operation kinds that travel from the front end to the sequencer.
	typedef enum logic [1:0] {
		OP_BYTE,
		OP_CLEAR,
		OP_INIT
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        rs;
		logic [7:0]  data;
	} op_t;

	typedef struct packed {
		logic        pulse;
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_us;
		logic        last;
	} step_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	localparam int unsigned IDX_W = 5;

	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME  = 8'h02;
	localparam logic [7:0] CMD_ROW0  = 8'h80;
	localparam logic [7:0] CMD_ROW1  = 8'hC0;
	localparam logic [7:0] SLOW_MASK = 8'hFC;

	localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
	localparam logic [3:0] INIT_NIB_4BIT = 4'h2;

	localparam logic [7:0] INIT_CMDS [6] = '{8'h28, 8'h08, 8'h01, 8'h02, 8'h06, 8'h0C};

	localparam logic [15:0] WAIT_NONE    = 16'd0;
	localparam logic [15:0] WAIT_CMD     = 16'd60;
	localparam logic [15:0] WAIT_SLOW    = 16'd1700;
	localparam logic [15:0] WAIT_DATA    = 16'd100;
	localparam logic [15:0] WAIT_NIB     = 16'd5000;
	localparam logic [15:0] WAIT_POWERUP = 16'd50000;

	localparam logic [IDX_W-1:0] LAST_BYTE      = 5'd1;
	localparam logic [IDX_W-1:0] LAST_CLEAR     = 5'd3;
	localparam logic [IDX_W-1:0] LAST_INIT      = 5'd16;
	localparam logic [IDX_W-1:0] INIT_NIB_LAST  = 5'd4;
	localparam logic [IDX_W-1:0] INIT_CMD_FIRST = 5'd5;

	// One half of a byte transfer; the low half carries the settling wait.
	function automatic step_t byte_step(logic rs, logic [7:0] data, logic low_half);
		step_t s;
		s = '0;
		s.pulse      = 1'b1;
		s.reg_select = rs;
		if (!low_half) begin
			s.nibble  = data[7:4];
			s.wait_us = WAIT_NONE;
		end else begin
			s.nibble = data[3:0];
			if (rs) begin
				s.wait_us = WAIT_DATA;
			end else if ((data & SLOW_MASK) != 8'h00) begin
				s.wait_us = WAIT_CMD;
			end else begin
				s.wait_us = WAIT_SLOW;
			end
		end
		return s;
	endfunction

	// Bus step number idx of an operation.
	function automatic step_t gen_step(op_t op, logic [IDX_W-1:0] idx);
		step_t            s;
		logic [IDX_W-1:0] c;
		s = '0;
		c = idx - INIT_CMD_FIRST;
		unique case (op.kind)
			OP_BYTE: begin
				s      = byte_step(op.rs, op.data, idx[0]);
				s.last = (idx == LAST_BYTE);
			end
			OP_CLEAR: begin
				s      = byte_step(1'b0, idx[1] ? CMD_HOME : CMD_CLEAR, idx[0]);
				s.last = (idx == LAST_CLEAR);
			end
			OP_INIT: begin
				if (idx == '0) begin
					s.wait_us = WAIT_POWERUP;
				end else if (idx <= INIT_NIB_LAST) begin
					s.pulse   = 1'b1;
					s.nibble  = (idx == INIT_NIB_LAST) ? INIT_NIB_4BIT : INIT_NIB_WAKE;
					s.wait_us = WAIT_NIB;
				end else begin
					s = byte_step(1'b0, INIT_CMDS[c[3:1]], c[0]);
				end
				s.last = (idx == LAST_INIT);
			end
			default: begin
				s.last = 1'b1;
			end
		endcase
		return s;
	endfunction

endpackage

>>> hdl/clns_ifs.sv
interface clns_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] value;
	logic [3:0] column;
	logic       row;

	modport source(output valid, output func, output value, output column, output row,
		input ready);
	modport sink(input valid, input func, input value, input column, input row,
		output ready);
endinterface

interface clns_step_if;
	logic        valid;
	logic        ready;
	logic        pulse;
	logic        reg_select;
	logic [3:0]  nibble;
	logic [15:0] wait_us;
	logic        last;

	modport source(output valid, output pulse, output reg_select, output nibble,
		output wait_us, output last, input ready);
	modport sink(input valid, input pulse, input reg_select, input nibble,
		input wait_us, input last, output ready);
endinterface

>>> hdl/clns_front.sv
// Takes requests and turns each one with a known function code into one queued operation.
module clns_front (
	clns_req_if.sink       req,
	input  logic           full,
	output logic           push,
	output clns_pkg::op_t  push_data
);

	logic accept;
	logic known;

	assign req.ready = !full;
	assign accept    = req.valid && !full;

	always_comb begin
		known     = 1'b1;
		push_data = '0;
		unique case (clns_pkg::func_t'(req.func))
			clns_pkg::FUNC_CMD: begin
				push_data.kind = clns_pkg::OP_BYTE;
				push_data.data = req.value;
			end
			clns_pkg::FUNC_DATA: begin
				push_data.kind = clns_pkg::OP_BYTE;
				push_data.rs   = 1'b1;
				push_data.data = req.value;
			end
			clns_pkg::FUNC_GOTO: begin
				push_data.kind = clns_pkg::OP_BYTE;
				push_data.data = (req.row ? clns_pkg::CMD_ROW1 : clns_pkg::CMD_ROW0)
					+ {4'h0, req.column};
			end
			clns_pkg::FUNC_CLEAR: begin
				push_data.kind = clns_pkg::OP_CLEAR;
			end
			clns_pkg::FUNC_INIT: begin
				push_data.kind = clns_pkg::OP_INIT;
			end
			default: begin
				// Unused codes are taken and dropped.
				known = 1'b0;
			end
		endcase
	end

	assign push = accept && known;

endmodule

>>> hdl/clns_queue.sv
// Small first-in first-out queue of classified operations.
module clns_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  clns_pkg::op_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output clns_pkg::op_t pop_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	clns_pkg::op_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/clns_back.sv
// Walks one operation through its bus steps and paces the enable framing.
module clns_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     cpu,
	input  logic           op_valid,
	input  clns_pkg::op_t  op,
	output logic           op_pop,
	clns_step_if.source    step
);

	clns_pkg::seq_state_t          state_q;
	clns_pkg::seq_state_t          state_d;
	clns_pkg::op_t                 op_q;
	logic [clns_pkg::IDX_W-1:0]    idx_q;
	logic                          gap_q;
	logic [7:0]                    pre_q;
	logic                          fr_q;
	logic                          out_valid_q;
	clns_pkg::step_t               out_q;
	clns_pkg::step_t               nxt;
	logic                          load;
	logic                          tick;

	assign nxt  = clns_pkg::gen_step(op_q, idx_q);
	assign load = (state_q == clns_pkg::SEQ_RUN) && !gap_q && (!out_valid_q || step.ready);
	assign tick = ({1'b0, pre_q} + 9'd1) >= {1'b0, cpu};

	always_comb begin
		state_d = state_q;
		op_pop  = 1'b0;
		unique case (state_q)
			clns_pkg::SEQ_IDLE: begin
				if (op_valid) begin
					op_pop  = 1'b1;
					state_d = clns_pkg::SEQ_RUN;
				end
			end
			clns_pkg::SEQ_RUN: begin
				if (load && nxt.last) begin
					state_d = clns_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = clns_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clns_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			gap_q <= 1'b0;
			pre_q <= '0;
			fr_q  <= 1'b0;
		end else begin
			if (op_pop) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
			// Enable high for one microsecond, then low for one.
			if (load && nxt.pulse) begin
				gap_q <= 1'b1;
				pre_q <= '0;
				fr_q  <= 1'b0;
			end else if (gap_q) begin
				if (tick) begin
					pre_q <= '0;
					if (fr_q) begin
						gap_q <= 1'b0;
					end else begin
						fr_q <= 1'b1;
					end
				end else begin
					pre_q <= pre_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (step.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	assign step.valid      = out_valid_q;
	assign step.pulse      = out_q.pulse;
	assign step.reg_select = out_q.reg_select;
	assign step.nibble     = out_q.nibble;
	assign step.wait_us    = out_q.wait_us;
	assign step.last       = out_q.last;

endmodule

>>> hdl/char_lcd_nibble_sequencer.sv
// Channel   Role     Word
// req       sink     func, value, column, row (one request)
// step      source   pulse, reg_select, nibble, wait_us, last (one bus step)
// cfg       write    cfg_we, cfg_data (clocks per microsecond)
//
// A request yields 2 steps (command, data, go to position), 4 (clear) or 17 (initialise).
// The sequencer takes an operation from the queue when idle and issues one step per cycle
// while the step output is not stalled, but each pulse step holds it for the enable framing,
// which the rate register paces. Reset empties the queue, idles the sequencer and clears the
// output valid flag; the rate register returns to 16. A stalled step output holds its word
// while the queue keeps taking requests until it is full.
module char_lcd_nibble_sequencer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	clns_req_if.sink    req,
	clns_step_if.source step
);

	// Clocks per microsecond; it paces the enable framing only and never
	// changes the content of a step.
	logic [7:0]    cpu_q;

	logic          push;
	clns_pkg::op_t push_data;
	logic          full;
	logic          pop;
	logic          pop_valid;
	clns_pkg::op_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q <= 8'd16;
		end else if (cfg_we) begin
			cpu_q <= cfg_data;
		end
	end

	// Front end: classify requests and drop unused function codes.
	clns_front u_front (
		.req       (req),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// The queue lets the front keep taking requests while the bus sequence runs.
	clns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	// Back end: expand each operation into its bus steps.
	clns_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cpu      (cpu_q),
		.op_valid (pop_valid),
		.op       (pop_data),
		.op_pop   (pop),
		.step     (step)
	);

endmodule

>>> hdl/clns_check.sv
module clns_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        pulse,
	input logic        reg_select,
	input logic [3:0]  nibble,
	input logic [15:0] wait_us,
	input logic        last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("step word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({pulse, reg_select, nibble, wait_us, last}))
		else $error("step word changed while stalled");

	// The only wait-only step is the power-up delay of the initialise sequence.
	a_wait_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pulse |-> reg_select == 1'b0 && nibble == 4'h0
			&& wait_us == 16'd50000 && last == 1'b0)
		else $error("malformed wait-only step");

	// Data transfers settle for 100 us after the low nibble and not at all after the high.
	a_data_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_select |-> pulse && (wait_us == 16'd0 || wait_us == 16'd100))
		else $error("bad wait on data step");

endmodule

bind char_lcd_nibble_sequencer clns_check u_clns_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (step.valid),
	.out_ready  (step.ready),
	.pulse      (step.pulse),
	.reg_select (step.reg_select),
	.nibble     (step.nibble),
	.wait_us    (step.wait_us),
	.last       (step.last)
);
